>>> sv/spq_pkg.sv
package spq_pkg;

  localparam int TAG_W = 32;
  localparam int PRI_W = 16;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_DEC = 2'd2,
    OP_CLR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_NOT_HIGHER = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_FULL       = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_CMP,
    S_DEQ,
    S_SRCH,
    S_REM,
    S_REM_SH,
    S_HEAD,
    S_LOAD
  } seq_state_t;

  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [PRI_W-1:0] pri;
  } slot_t;

  // compare of one stored slot against the working key
  typedef struct packed {
    logic precedes; // slot key sorts strictly ahead of working key
    logic tag_eq;   // slot tag equals working tag
    logic pri_le;   // slot priority <= working priority
  } cmp_res_t;

endpackage

>>> sv/sorted_priority_queue_decrease_key_core.sv
// Sorted priority queue with decrease-key.
// Input channel (in_valid/in_stall) carries one item: opcode, item_tag, item_priority.
// Opcodes: enqueue, dequeue, decrease priority of a tag, clear. Output channel
// (out_valid/out_stall) returns exactly one result item per input item: status,
// removed tag, head tag/priority, entry count and empty flag after the operation.
// Entries sit in one slot memory in ascending (priority, tag) order, slot 0 = head.
// A small sequencer walks the memory one slot per cycle through a single shared
// key compare unit; the memory has one write and one registered read port.
// in_stall is high from acceptance until the result is loaded into the output
// register; the result shows on the first cycle the block is ready again.
// Enqueue runs an insert shift and dequeue a remove shift; a decrease that moves
// its entry runs a search, a remove shift and an insert shift. Clear and ops
// rejected on an empty or full queue go straight to the head read.
// The result register lets the block take the next item while a result waits;
// if the receiver stalls, a second finished result holds in the sequencer
// until the first is taken. Reset (rst, synchronous) empties the queue and
// drops any pending result; slot contents are not cleared.
module sorted_priority_queue_decrease_key_core #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic [spq_pkg::TAG_W-1:0]         item_tag,
  input  logic signed [spq_pkg::PRI_W-1:0]  item_priority,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic [spq_pkg::TAG_W-1:0]         removed_tag,
  output logic [spq_pkg::TAG_W-1:0]         head_tag,
  output logic signed [spq_pkg::PRI_W-1:0]  head_priority,
  output logic [4:0]                        entry_total,
  output logic                              queue_empty
);

  localparam int CW = $clog2(DEPTH + 1);  // count 0..DEPTH
  localparam int IW = $clog2(DEPTH);      // slot address

  spq_pkg::seq_state_t st, st_next;
  logic [CW-1:0]       occ, occ_next;
  logic [CW-1:0]       idx, idx_next;   // hole position / scan position
  spq_pkg::op_t        op;
  logic [spq_pkg::TAG_W-1:0]        key_tag;
  logic signed [spq_pkg::PRI_W-1:0] key_pri;
  spq_pkg::status_t    sts, sts_next;
  logic [spq_pkg::TAG_W-1:0]        removed, removed_next;

  logic                accept;
  logic                load_out;

  // slot memory ports
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  spq_pkg::slot_t      wr_slot;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  spq_pkg::slot_t      rd_slot;
  spq_pkg::cmp_res_t   cmp;

  assign in_stall = (st != spq_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  spq_store #(.DEPTH(DEPTH), .IW(IW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_slot (wr_slot),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_slot (rd_slot)
  );

  // shared key compare: stored slot (memory read data) vs working key
  spq_cmp u_cmp (
    .slot    (rd_slot),
    .key_tag (key_tag),
    .key_pri (key_pri),
    .res     (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= spq_pkg::S_IDLE;
      occ <= '0;
    end else begin
      st  <= st_next;
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    sts     <= sts_next;
    removed <= removed_next;
    if (accept) begin
      op      <= spq_pkg::op_t'(opcode);
      key_tag <= item_tag;
      key_pri <= item_priority;
    end
  end

  // sequencer
  always_comb begin
    st_next      = st;
    occ_next     = occ;
    idx_next     = idx;
    sts_next     = sts;
    removed_next = removed;
    wr_en        = 1'b0;
    wr_addr      = idx[IW-1:0];
    wr_slot      = '{tag: key_tag, pri: key_pri};
    rd_en        = 1'b0;
    rd_addr      = '0;
    load_out     = 1'b0;

    unique case (st)
      spq_pkg::S_IDLE: begin
        if (in_valid) begin
          sts_next     = spq_pkg::ST_OK;
          removed_next = '0;
          unique case (spq_pkg::op_t'(opcode))
            spq_pkg::OP_ENQ: begin
              if (occ == CW'(DEPTH)) begin
                sts_next = spq_pkg::ST_FULL;
                st_next  = spq_pkg::S_HEAD;
              end else begin
                idx_next = occ;
                st_next  = spq_pkg::S_INS;
              end
            end
            spq_pkg::OP_DEQ: begin
              if (occ == '0) begin
                sts_next = spq_pkg::ST_EMPTY;
                st_next  = spq_pkg::S_HEAD;
              end else begin
                rd_en   = 1'b1;
                st_next = spq_pkg::S_DEQ;
              end
            end
            spq_pkg::OP_DEC: begin
              if (occ == '0) begin
                sts_next = spq_pkg::ST_EMPTY;
                st_next  = spq_pkg::S_HEAD;
              end else begin
                rd_en    = 1'b1;
                idx_next = '0;
                st_next  = spq_pkg::S_SRCH;
              end
            end
            spq_pkg::OP_CLR: begin
              occ_next = '0;
              st_next  = spq_pkg::S_HEAD;
            end
            default: ;
          endcase
        end
      end

      // idx is the hole; compare against the slot just above it
      spq_pkg::S_INS: begin
        if (idx == '0) begin
          wr_en    = 1'b1;
          occ_next = occ + CW'(1);
          st_next  = spq_pkg::S_HEAD;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx - CW'(1));
          st_next = spq_pkg::S_INS_CMP;
        end
      end

      // rd_slot = slot[idx-1]
      spq_pkg::S_INS_CMP: begin
        wr_en = 1'b1;
        if (cmp.precedes) begin
          occ_next = occ + CW'(1);
          st_next  = spq_pkg::S_HEAD;
        end else begin
          wr_slot  = rd_slot;
          idx_next = idx - CW'(1);
          if (idx == CW'(1)) begin
            st_next = spq_pkg::S_INS;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IW'(idx - CW'(2));
          end
        end
      end

      // rd_slot = head
      spq_pkg::S_DEQ: begin
        removed_next = rd_slot.tag;
        idx_next     = '0;
        st_next      = spq_pkg::S_REM;
      end

      // rd_slot = slot[idx]
      spq_pkg::S_SRCH: begin
        if (cmp.tag_eq) begin
          if (cmp.pri_le) begin
            sts_next = spq_pkg::ST_NOT_HIGHER;
            st_next  = spq_pkg::S_HEAD;
          end else begin
            st_next = spq_pkg::S_REM;
          end
        end else if ((idx + CW'(1)) < occ) begin
          rd_en    = 1'b1;
          rd_addr  = IW'(idx + CW'(1));
          idx_next = idx + CW'(1);
        end else begin
          sts_next = spq_pkg::ST_NOT_FOUND;
          st_next  = spq_pkg::S_HEAD;
        end
      end

      // remove slot idx by shifting the tail up one place
      spq_pkg::S_REM: begin
        if ((idx + CW'(1)) < occ) begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx + CW'(1));
          st_next = spq_pkg::S_REM_SH;
        end else begin
          occ_next = occ - CW'(1);
          if (op == spq_pkg::OP_DEC) begin
            idx_next = occ - CW'(1);
            st_next  = spq_pkg::S_INS;
          end else begin
            st_next = spq_pkg::S_HEAD;
          end
        end
      end

      // rd_slot = slot[idx+1]
      spq_pkg::S_REM_SH: begin
        wr_en    = 1'b1;
        wr_slot  = rd_slot;
        idx_next = idx + CW'(1);
        if ((idx + CW'(2)) < occ) begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx + CW'(2));
        end else begin
          occ_next = occ - CW'(1);
          if (op == spq_pkg::OP_DEC) begin
            idx_next = occ - CW'(1);
            st_next  = spq_pkg::S_INS;
          end else begin
            st_next = spq_pkg::S_HEAD;
          end
        end
      end

      spq_pkg::S_HEAD: begin
        rd_en   = 1'b1;
        st_next = spq_pkg::S_LOAD;
      end

      // rd_slot = head; wait here while an older result is still stalled
      spq_pkg::S_LOAD: begin
        if (!out_valid || !out_stall) begin
          load_out = 1'b1;
          st_next  = spq_pkg::S_IDLE;
        end
      end

      default: st_next = spq_pkg::S_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= sts;
      removed_tag <= removed;
      entry_total <= 5'(occ);
      queue_empty <= (occ == '0);
      if (occ == '0) begin
        head_tag      <= '0;
        head_priority <= '0;
      end else begin
        head_tag      <= rd_slot.tag;
        head_priority <= rd_slot.pri;
      end
    end
  end

endmodule

>>> sv/spq_store.sv
module spq_store #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IW-1:0]     wr_addr,
  input  spq_pkg::slot_t    wr_slot,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output spq_pkg::slot_t    rd_slot
);

  spq_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_slot;
    end
    if (rd_en) begin
      rd_slot <= mem[rd_addr];
    end
  end

endmodule

>>> sv/spq_cmp.sv
module spq_cmp (
  input  spq_pkg::slot_t                      slot,
  input  logic [spq_pkg::TAG_W-1:0]           key_tag,
  input  logic signed [spq_pkg::PRI_W-1:0]    key_pri,
  output spq_pkg::cmp_res_t                   res
);

  logic pri_lt;
  logic pri_eq;

  always_comb begin
    pri_lt       = $signed(slot.pri) < key_pri;
    pri_eq       = $signed(slot.pri) == key_pri;
    res.tag_eq   = slot.tag == key_tag;
    res.precedes = pri_lt || (pri_eq && (slot.tag < key_tag));
    res.pri_le   = pri_lt || pri_eq;
  end

endmodule

>>> sv/spq_chk.sv
module spq_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [2:0]                        status,
  input logic [spq_pkg::TAG_W-1:0]         removed_tag,
  input logic [spq_pkg::TAG_W-1:0]         head_tag,
  input logic signed [spq_pkg::PRI_W-1:0]  head_priority,
  input logic [4:0]                        entry_total,
  input logic                              queue_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer not busy after accepting an item");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && queue_empty |->
      head_tag == '0 && head_priority == '0 && entry_total == '0)
    else $error("empty queue reports a head");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && removed_tag != '0 |-> status == spq_pkg::ST_OK)
    else $error("removed tag on failed operation");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_EMPTY |-> queue_empty)
    else $error("empty status on non-empty queue");

endmodule

bind sorted_priority_queue_decrease_key_core spq_chk u_spq_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .removed_tag   (removed_tag),
  .head_tag      (head_tag),
  .head_priority (head_priority),
  .entry_total   (entry_total),
  .queue_empty   (queue_empty)
);
